@@ src/sc1a_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scancode set 1 decoder package
// Byte codes, state and result types, and the per-byte decode function for
// the US-layout scancode set 1 keyboard decoder.
// ----------------------------------------------------------------------------
package sc1a_pkg;

  localparam logic [7:0] BYTE_ACK      = 8'hFA;
  localparam logic [7:0] BYTE_RESEND   = 8'hFE;
  localparam logic [7:0] BYTE_SELFTEST = 8'hAA;
  localparam logic [7:0] BYTE_BREAK    = 8'hF0;
  localparam logic [7:0] BYTE_EXT      = 8'hE0;

  localparam logic [6:0] CODE_CTRL     = 7'h1D;
  localparam logic [6:0] CODE_ENTER    = 7'h1C;
  localparam logic [6:0] CODE_PGUP     = 7'h49;
  localparam logic [6:0] CODE_PGDN     = 7'h51;
  localparam logic [6:0] CODE_SLASH    = 7'h35;
  localparam logic [6:0] CODE_KP_MINUS = 7'h4A;

  localparam logic [7:0] KEY_PGUP      = 8'hF1;
  localparam logic [7:0] KEY_PGDN      = 8'hF2;
  localparam logic [7:0] CH_NONE       = 8'h00;
  localparam logic [7:0] CH_BS         = 8'h08;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_A          = 8'h61;
  localparam logic [7:0] CH_Z          = 8'h7A;
  localparam logic [7:0] CTRL_OFFSET   = 8'h60;

  typedef struct packed {
    logic skip;
    logic ext;
    logic lctrl;
    logic rctrl;
  } sc1a_state_t;

  typedef struct packed {
    logic        emit;
    logic [7:0]  code;
    logic        ctrl;
    sc1a_state_t state;
  } sc1a_result_t;

  function automatic logic [7:0] plain_map(input logic [6:0] c);
    logic [7:0] ch;
    unique case (c)
      7'h02: ch = "1";
      7'h03: ch = "2";
      7'h04: ch = "3";
      7'h05: ch = "4";
      7'h06: ch = "5";
      7'h07: ch = "6";
      7'h08: ch = "7";
      7'h09: ch = "8";
      7'h0A: ch = "9";
      7'h0B: ch = "0";
      7'h0C: ch = CH_MINUS;
      7'h0E: ch = CH_BS;
      7'h0F: ch = CH_TAB;
      7'h10: ch = "q";
      7'h11: ch = "w";
      7'h12: ch = "e";
      7'h13: ch = "r";
      7'h14: ch = "t";
      7'h15: ch = "y";
      7'h16: ch = "u";
      7'h17: ch = "i";
      7'h18: ch = "o";
      7'h19: ch = "p";
      7'h1C: ch = CH_LF;
      7'h1E: ch = "a";
      7'h1F: ch = "s";
      7'h20: ch = "d";
      7'h21: ch = "f";
      7'h22: ch = "g";
      7'h23: ch = "h";
      7'h24: ch = "j";
      7'h25: ch = "k";
      7'h26: ch = "l";
      7'h2C: ch = "z";
      7'h2D: ch = "x";
      7'h2E: ch = "c";
      7'h2F: ch = "v";
      7'h30: ch = "b";
      7'h31: ch = "n";
      7'h32: ch = "m";
      7'h33: ch = ",";
      7'h34: ch = ".";
      7'h35: ch = CH_MINUS;
      7'h39: ch = " ";
      7'h4A: ch = CH_MINUS;
      default: ch = CH_NONE;
    endcase
    return ch;
  endfunction

  // Decodes one byte against the current flags and returns the new flags and
  // the key event, if any.
  function automatic sc1a_result_t sc1a_decode(input logic [7:0] b,
                                               input sc1a_state_t st);
    sc1a_result_t r;
    logic [7:0]   ch;
    r.emit  = 1'b0;
    r.code  = CH_NONE;
    r.ctrl  = st.lctrl | st.rctrl;
    r.state = st;
    ch      = plain_map(b[6:0]);
    priority if (b == BYTE_ACK || b == BYTE_RESEND || b == BYTE_SELFTEST) begin
      r.emit = 1'b0;
    end else if (b == BYTE_BREAK) begin
      r.state.skip = 1'b1;
    end else if (st.skip) begin
      r.state.skip = 1'b0;
    end else if (b == BYTE_EXT) begin
      r.state.ext = 1'b1;
    end else if (b[7]) begin
      // Release: only Ctrl keys are tracked.
      if (st.ext) begin
        if (b[6:0] == CODE_CTRL) begin
          r.state.rctrl = 1'b0;
        end
        r.state.ext = 1'b0;
      end else if (b[6:0] == CODE_CTRL) begin
        r.state.lctrl = 1'b0;
      end
    end else if (st.ext) begin
      r.state.ext = 1'b0;
      unique case (b[6:0])
        CODE_CTRL:     r.state.rctrl = 1'b1;
        CODE_ENTER:    begin r.emit = 1'b1; r.code = CH_LF;    end
        CODE_PGUP:     begin r.emit = 1'b1; r.code = KEY_PGUP; end
        CODE_PGDN:     begin r.emit = 1'b1; r.code = KEY_PGDN; end
        CODE_SLASH:    begin r.emit = 1'b1; r.code = CH_SLASH; end
        CODE_KP_MINUS: begin r.emit = 1'b1; r.code = CH_MINUS; end
        default:       r.emit = 1'b0;
      endcase
    end else if (b[6:0] == CODE_CTRL) begin
      r.state.lctrl = 1'b1;
    end else if (ch != CH_NONE) begin
      r.emit = 1'b1;
      if (r.ctrl && ch >= CH_A && ch <= CH_Z) begin
        r.code = ch - CTRL_OFFSET;
      end else begin
        r.code = ch;
      end
    end else begin
      // A make code without a table entry is ignored.
      r.emit = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/scancode_set1_to_ascii_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scancode set 1 to ASCII decoder
// Decodes a stream of keyboard bytes (US layout, scancode set 1) into key
// events carrying an ASCII code and the Ctrl state.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  input    in         in_valid / in_stall   scan_byte[7:0]
//  output   out        out_valid / out_stall key_char[7:0], ctrl_held
//
//  One byte is accepted per cycle while in_stall is low; a key event passes
//  through the input register, is then decoded into the result register,
//  and is presented from the result register.
//  The decode and flag update sit in one short logic path between the two.
//  Reset clears the prefix and Ctrl flags and both valid bits.
//  A stalled output holds its transaction; the input register keeps taking
//  bytes until it is full behind the stalled result.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii_top
  import sc1a_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] scan_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      key_char,
  output logic            ctrl_held
);

  logic         s1_valid;
  logic [7:0]   s1_byte;
  sc1a_state_t  flags;
  sc1a_result_t dec;
  logic         out_ready;
  logic         s1_go;

  assign out_ready = !out_valid || !out_stall;
  assign s1_go     = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;
  assign dec       = sc1a_decode(s1_byte, flags);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= scan_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (s1_go) begin
      flags <= dec.state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_go && dec.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && dec.emit) begin
      key_char  <= dec.code;
      ctrl_held <= dec.ctrl;
    end
  end

  // Control codes other than backspace, tab and line feed only come from Ctrl.
  a_ctrl_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && key_char >= 8'd1 && key_char <= 8'd26 && key_char != CH_BS &&
     key_char != CH_TAB && key_char != CH_LF) |-> ctrl_held)
    else $error("control code emitted without Ctrl held");

  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> key_char != CH_NONE)
    else $error("null key code emitted");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> s1_valid && $stable(s1_byte))
    else $error("input register lost a byte while stalled");

  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_go |=> $stable(flags))
    else $error("flags changed without a byte being decoded");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid && flags == '0)
    else $error("reset did not clear control state");

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scancode set 1 decoder testbench
// Feeds keyboard bytes into the decoder with random gaps and output stalls,
// predicts every key event with an independent decoder model held in a
// scoreboard, and compares each event field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  import sc1a_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 650;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned MAX_REPORTS    = 10;

  // Scancodes used by name in the directed part.
  localparam logic [7:0] SC_NULL   = 8'h00;
  localparam logic [7:0] SC_TOP    = 8'hFF;
  localparam logic [7:0] SC_KEY_A  = 8'h1E;
  localparam logic [7:0] SC_KEY_Q  = 8'h10;
  localparam logic [7:0] SC_KEY_Z  = 8'h2C;
  localparam logic [7:0] SC_KEY_1  = 8'h02;
  localparam logic [7:0] SC_SPACE  = 8'h39;
  localparam logic [7:0] SC_BKSP   = 8'h0E;
  localparam logic [7:0] REL_FLAG  = 8'h80;

  typedef struct {
    logic [7:0] code;
    logic       ctrl;
  } key_event_t;

  class key_scoreboard;
    bit           skip_armed;
    bit           ext_armed;
    bit           lctrl;
    bit           rctrl;
    key_event_t   pending[$];
    int unsigned  bytes_in;
    int unsigned  keys_seen;
    int unsigned  ctrl_keys;
    int unsigned  errors;
    string        digit_row  = "1234567890-";
    string        upper_row  = "qwertyuiop";
    string        home_row   = "asdfghjkl";
    string        lower_row  = "zxcvbnm,.";

    function logic [7:0] plain_char(logic [6:0] c);
      if (c >= 7'h02 && c <= 7'h0C) return digit_row[c - 7'h02];
      if (c >= 7'h10 && c <= 7'h19) return upper_row[c - 7'h10];
      if (c >= 7'h1E && c <= 7'h26) return home_row[c - 7'h1E];
      if (c >= 7'h2C && c <= 7'h34) return lower_row[c - 7'h2C];
      case (c)
        7'h0E:         return CH_BS;
        7'h0F:         return CH_TAB;
        CODE_ENTER:    return CH_LF;
        CODE_SLASH:    return CH_MINUS;
        7'h39:         return 8'h20;
        CODE_KP_MINUS: return CH_MINUS;
        default:       return CH_NONE;
      endcase
    endfunction

    function void fault(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Updates the prefix and Ctrl flags for one accepted byte and queues the
    // key event that it produces, if any.
    function void note_byte(logic [7:0] b);
      key_event_t ev;
      bit         emit;
      logic [7:0] ch;
      emit = 1'b0;
      ch   = CH_NONE;
      bytes_in++;
      if (!(b == BYTE_ACK || b == BYTE_RESEND || b == BYTE_SELFTEST)) begin
        if (b == BYTE_BREAK) begin
          skip_armed = 1'b1;
        end else if (skip_armed) begin
          skip_armed = 1'b0;
        end else if (b == BYTE_EXT) begin
          ext_armed = 1'b1;
        end else if (b[7]) begin
          if (b[6:0] == CODE_CTRL) begin
            if (ext_armed) rctrl = 1'b0;
            else lctrl = 1'b0;
          end
          ext_armed = 1'b0;
        end else if (ext_armed) begin
          ext_armed = 1'b0;
          emit = 1'b1;
          case (b[6:0])
            CODE_CTRL:     begin rctrl = 1'b1; emit = 1'b0; end
            CODE_ENTER:    ch = CH_LF;
            CODE_PGUP:     ch = KEY_PGUP;
            CODE_PGDN:     ch = KEY_PGDN;
            CODE_SLASH:    ch = CH_SLASH;
            CODE_KP_MINUS: ch = CH_MINUS;
            default:       emit = 1'b0;
          endcase
        end else if (b[6:0] == CODE_CTRL) begin
          lctrl = 1'b1;
        end else begin
          ch   = plain_char(b[6:0]);
          emit = (ch != CH_NONE);
          if (emit && (lctrl || rctrl) && ch >= CH_A && ch <= CH_Z) ch = ch - CTRL_OFFSET;
        end
      end
      if (emit) begin
        ev.code = ch;
        ev.ctrl = lctrl | rctrl;
        pending.push_back(ev);
      end
    endfunction

    function void check_key(logic [7:0] code, logic ctrl);
      key_event_t ev;
      if (pending.size() == 0) begin
        fault($sformatf("unexpected key event code=%h ctrl=%b", code, ctrl));
        return;
      end
      ev = pending.pop_front();
      keys_seen++;
      if (ctrl === 1'b1) ctrl_keys++;
      if (code !== ev.code || ctrl !== ev.ctrl) begin
        fault($sformatf("key event %0d: expected code=%h ctrl=%b, got code=%h ctrl=%b",
                        keys_seen, ev.code, ev.ctrl, code, ctrl));
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] scan_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] key_char;
  logic       ctrl_held;

  key_scoreboard sb = new();
  bit            idle_on = 1'b1;
  bit            moved;
  int unsigned   quiet_cycles;
  int unsigned   counted_items;

  scancode_set1_to_ascii_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .scan_byte (scan_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .key_char  (key_char),
    .ctrl_held (ctrl_held)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= idle_on && ($urandom_range(0, 99) < 9);
    end
  end

  // Transaction monitor and watchdog: both channels are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        sb.note_byte(scan_byte);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        sb.check_key(key_char, ctrl_held);
        moved = 1'b1;
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b);
    while (idle_on && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    scan_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (!(b == BYTE_ACK || b == BYTE_RESEND || b == BYTE_SELFTEST)) counted_items++;
  endtask

  task automatic send_random_sequence();
    logic [7:0] ext_codes[6];
    logic [7:0] rb;
    int unsigned pick;
    ext_codes = '{{1'b0, CODE_CTRL}, {1'b0, CODE_ENTER}, {1'b0, CODE_PGUP},
                  {1'b0, CODE_PGDN}, {1'b0, CODE_SLASH}, {1'b0, CODE_KP_MINUS}};
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      rb = 8'($urandom_range(0, 127));
      send_byte(rb);
    end else if (pick < 45) begin
      rb = 8'($urandom_range(128, 255));
      send_byte(rb);
    end else if (pick < 57) begin
      // Ctrl press or release, left or right.
      rb = {$urandom_range(0, 1) ? REL_FLAG[7] : 1'b0, CODE_CTRL};
      if ($urandom_range(0, 1)) send_byte(BYTE_EXT);
      send_byte(rb);
    end else if (pick < 72) begin
      send_byte(BYTE_EXT);
      if ($urandom_range(0, 9) < 7) rb = ext_codes[$urandom_range(0, 5)];
      else rb = 8'($urandom_range(0, 255));
      send_byte(rb);
    end else if (pick < 80) begin
      send_byte(BYTE_BREAK);
      rb = 8'($urandom_range(0, 255));
      send_byte(rb);
    end else if (pick < 85) begin
      case ($urandom_range(0, 2))
        0:       send_byte(BYTE_ACK);
        1:       send_byte(BYTE_RESEND);
        default: send_byte(BYTE_SELFTEST);
      endcase
    end else begin
      rb = 8'($urandom_range(0, 255));
      send_byte(rb);
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    rst       = 1'b1;
    in_valid  = 1'b0;
    scan_byte = 8'h00;
    counted_items = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed = '{SC_NULL, SC_TOP, SC_KEY_A, SC_SPACE, SC_BKSP,
                 BYTE_ACK, BYTE_RESEND, BYTE_SELFTEST,
                 {1'b0, CODE_CTRL}, SC_KEY_Q, SC_KEY_1,
                 BYTE_EXT, {1'b0, CODE_CTRL}, BYTE_EXT, {1'b0, CODE_ENTER},
                 {REL_FLAG[7], CODE_CTRL}, SC_KEY_Z,
                 BYTE_EXT, {REL_FLAG[7], CODE_CTRL},
                 BYTE_EXT, {1'b0, CODE_PGUP}, BYTE_EXT, {1'b0, CODE_PGDN},
                 BYTE_EXT, {1'b0, CODE_SLASH}, BYTE_EXT, {1'b0, CODE_KP_MINUS},
                 BYTE_EXT, SC_KEY_Q,
                 BYTE_BREAK, BYTE_BREAK, BYTE_SELFTEST, SC_KEY_A,
                 BYTE_BREAK, BYTE_EXT, SC_KEY_A,
                 BYTE_EXT, BYTE_ACK, (SC_KEY_A | REL_FLAG), SC_KEY_Z};
    foreach (directed[i]) send_byte(directed[i]);

    // A stretch in the middle of the random part runs with no gaps or stalls.
    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      idle_on = !(counted_items >= 250 && counted_items < 400);
      send_random_sequence();
    end
    idle_on = 1'b1;
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending.size() != 0) sb.fault($sformatf("%0d key events never arrived",
                                                   sb.pending.size()));
    $display("decoded %0d keyboard bytes into %0d key events, %0d of them with Ctrl held",
             sb.bytes_in, sb.keys_seen, sb.ctrl_keys);
    $display("%0d failures found", sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
